/* src/frt_pkg.sv */
// shared widths, constants and types of the frame rotate/translate block
`default_nettype none

package frt_pkg;

  localparam int ROTATION_STAGES = 16;
  localparam int ANG_TABLE_LEN   = 24;
  localparam int CORDIC_STAGES   =
    (ROTATION_STAGES < ANG_TABLE_LEN) ? ROTATION_STAGES : ANG_TABLE_LEN;

  localparam int COORD_W = 24;
  localparam int HDG_W   = 17;
  localparam int ANG_W   = 32;
  localparam int ZR_W    = ANG_W + 1;
  localparam int CS_W    = 33;
  localparam int TRIG_W  = 32;
  localparam int FRAC_W  = 30;
  localparam int OP_W    = COORD_W + 1;
  localparam int PROD_W  = TRIG_W + OP_W;
  localparam int SUM_W   = PROD_W + 2;

  localparam int COORD_MAX = 2 ** (COORD_W - 1) - 1;
  localparam int COORD_MIN = -(2 ** (COORD_W - 1));

  // heading to binary angle: a = 119304*h + (1456*h + 1125) / 2250
  localparam int HDG_TURN      = 36000;
  localparam int HR_W          = 16;
  localparam int HDG_WHOLE     = 119304;
  localparam int HDG_FRAC_MUL  = 1456;
  localparam int HDG_FRAC_BIAS = 1125;
  localparam int HDG_DIV       = 2250;
  localparam int U_W           = 26;
  localparam int RECIP_SHIFT   = 37;
  localparam int HDG_RECIP     = 61083979;
  localparam int Q_W           = 15;

  localparam logic signed [CS_W-1:0] CORDIC_GAIN = 33'sd652032874;

  localparam logic [ANG_W-1:0] ATAN_TURN32 [ANG_TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic                      req_type;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] pose_x;
    logic signed [COORD_W-1:0] pose_y;
    logic                      flip;
  } frt_side_t;

  typedef struct packed {
    logic                      overflow;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
  } frt_res_t;

endpackage

`default_nettype wire

/* src/frame_rotate_translate.sv */
// top level: 2-d rigid transform between robot frame and world frame
`default_nettype none

// Takes one request per clock while in_stall_o is low and returns one result per
// clock while out_stall_i is low. A request with req_type 0 maps a robot-frame
// point to world coordinates (R*p + r), req_type 1 maps a world point into the
// robot frame (R^T*(p - r)); heading is in hundredths of a degree, any 17-bit
// value, reduced modulo one turn. The heading is turned into a binary angle, an
// input register and one register per cordic stage (16 at the default) produce
// cosine and sine, then registers hold the selected operands, the products and
// the sums, and the result saturates into the output register. Every stage is a
// register, so throughput is one request per cycle; a stalled result parks in a
// one-entry skid stage and the pipeline only holds while that stage is full. out_x
// and out_y saturate to the 24-bit range and overflow flags that either one was clipped.
module frame_rotate_translate (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               req_type_i,
  input  logic signed [frt_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [frt_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [frt_pkg::COORD_W-1:0] pose_x_i,
  input  logic signed [frt_pkg::COORD_W-1:0] pose_y_i,
  input  logic signed [frt_pkg::HDG_W-1:0]   pose_heading_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [frt_pkg::COORD_W-1:0] out_x_o,
  output logic signed [frt_pkg::COORD_W-1:0] out_y_o,
  output logic                               overflow_o
);
  import frt_pkg::*;

  localparam int PRE_STG = 5;
  localparam int HP_W    = HDG_W + 2;
  localparam int P_W     = 2 * U_W;

  localparam logic signed [ZR_W-1:0]  QTURN      = ZR_W'(1) <<< (ANG_W - 2);
  localparam logic signed [ZR_W-1:0]  HTURN      = ZR_W'(1) <<< (ANG_W - 1);
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);

  function automatic logic [COORD_W:0] frt_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] sh;
    logic [COORD_W:0]        r;
    sh = v >>> FRAC_W;
    if (sh > SUM_W'(COORD_MAX)) begin
      r = {1'b1, COORD_W'(COORD_MAX)};
    end else if (sh < SUM_W'(COORD_MIN)) begin
      r = {1'b1, COORD_W'(COORD_MIN)};
    end else begin
      r = {1'b0, sh[COORD_W-1:0]};
    end
    return r;
  endfunction

  logic en;
  logic skid_v_q, out_v_q;
  frt_res_t out_res_q, skid_res_q, res_d;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // ---------------- heading to binary angle ----------------
  logic [PRE_STG-1:0] pre_v_q;
  frt_side_t          side_q [PRE_STG];
  frt_side_t          side_in;

  logic signed [HP_W-1:0] hdg_shift;
  logic [HP_W-2:0]        hdg_pos;
  logic [HR_W-1:0]        hr_d, hr1_q;
  logic [U_W-1:0]         u2_q, u3_q, rem;
  logic [ANG_W-1:0]       base2_q, base3_q, base4_q, a5_q;
  logic [P_W-1:0]         p3_q;
  logic [Q_W-1:0]         q_est, q_d, q4_q;

  always_comb begin
    side_in.req_type = req_type_i;
    side_in.point_x  = point_x_i;
    side_in.point_y  = point_y_i;
    side_in.pose_x   = pose_x_i;
    side_in.pose_y   = pose_y_i;
    side_in.flip     = 1'b0;
  end

  // shift into positive range, then at most three turns come off
  assign hdg_shift = HP_W'(pose_heading_i) + HP_W'(2 * HDG_TURN);
  assign hdg_pos   = hdg_shift[HP_W-2:0];

  always_comb begin
    priority if (hdg_pos >= (HP_W-1)'(3 * HDG_TURN)) begin
      hr_d = HR_W'(hdg_pos - (HP_W-1)'(3 * HDG_TURN));
    end else if (hdg_pos >= (HP_W-1)'(2 * HDG_TURN)) begin
      hr_d = HR_W'(hdg_pos - (HP_W-1)'(2 * HDG_TURN));
    end else if (hdg_pos >= (HP_W-1)'(HDG_TURN)) begin
      hr_d = HR_W'(hdg_pos - (HP_W-1)'(HDG_TURN));
    end else begin
      hr_d = HR_W'(hdg_pos);
    end
  end

  // reciprocal estimate is low by at most one
  assign q_est = Q_W'(p3_q >> RECIP_SHIFT);
  assign rem   = u3_q - U_W'(q_est) * U_W'(HDG_DIV);
  assign q_d   = (rem >= U_W'(HDG_DIV)) ? q_est + Q_W'(1) : q_est;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q <= '0;
    end else if (en) begin
      pre_v_q <= {pre_v_q[PRE_STG-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int k = 1; k < PRE_STG; k++) begin
        side_q[k] <= side_q[k-1];
      end
      hr1_q   <= hr_d;
      u2_q    <= U_W'(hr1_q) * U_W'(HDG_FRAC_MUL) + U_W'(HDG_FRAC_BIAS);
      base2_q <= ANG_W'(hr1_q) * ANG_W'(HDG_WHOLE);
      p3_q    <= P_W'(u2_q) * P_W'(HDG_RECIP);
      u3_q    <= u2_q;
      base3_q <= base2_q;
      q4_q    <= q_d;
      base4_q <= base3_q;
      a5_q    <= base4_q + ANG_W'(q4_q);
    end
  end

  // fold into the right half plane, undo with a sign flip afterwards
  logic signed [ZR_W-1:0] za, z_fold;
  frt_side_t              side_fold;

  assign za = ZR_W'(signed'(a5_q));

  always_comb begin
    side_fold = side_q[PRE_STG-1];
    priority if (za > QTURN) begin
      z_fold         = za - HTURN;
      side_fold.flip = 1'b1;
    end else if (za < -QTURN) begin
      z_fold         = za + HTURN;
      side_fold.flip = 1'b1;
    end else begin
      z_fold         = za;
      side_fold.flip = 1'b0;
    end
  end

  // ---------------- sine and cosine ----------------
  logic                     cv;
  logic signed [TRIG_W-1:0] cos_w, sin_w;
  frt_side_t                cside;

  frt_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pre_v_q[PRE_STG-1]),
    .z_i     (z_fold),
    .side_i  (side_fold),
    .valid_o (cv),
    .cos_o   (cos_w),
    .sin_o   (sin_w),
    .side_o  (cside)
  );

  // ---------------- rotate and translate ----------------
  // world to robot reuses the same form with sine negated and no offset
  logic [2:0]                post_v_q;
  logic signed [TRIG_W-1:0]  cos_q, sin_q;
  logic signed [OP_W-1:0]    ux_q, uy_q;
  logic signed [COORD_W-1:0] ox_q, oy_q, ox_m_q, oy_m_q;
  logic signed [PROD_W-1:0]  m_cx_q, m_sy_q, m_sx_q, m_cy_q;
  logic signed [SUM_W-1:0]   sx_q, sy_q;
  logic [COORD_W:0]          sat_x, sat_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_v_q <= '0;
    end else if (en) begin
      post_v_q <= {post_v_q[1:0], cv};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cos_q <= cside.flip ? -cos_w : cos_w;
      sin_q <= (cside.flip ^ cside.req_type) ? -sin_w : sin_w;
      if (cside.req_type) begin
        ux_q <= OP_W'(cside.point_x) - OP_W'(cside.pose_x);
        uy_q <= OP_W'(cside.point_y) - OP_W'(cside.pose_y);
        ox_q <= '0;
        oy_q <= '0;
      end else begin
        ux_q <= OP_W'(cside.point_x);
        uy_q <= OP_W'(cside.point_y);
        ox_q <= cside.pose_x;
        oy_q <= cside.pose_y;
      end
      m_cx_q <= cos_q * ux_q;
      m_sy_q <= sin_q * uy_q;
      m_sx_q <= sin_q * ux_q;
      m_cy_q <= cos_q * uy_q;
      ox_m_q <= ox_q;
      oy_m_q <= oy_q;
      sx_q   <= SUM_W'(m_cx_q) - SUM_W'(m_sy_q) + (SUM_W'(ox_m_q) <<< FRAC_W) + ROUND_HALF;
      sy_q   <= SUM_W'(m_sx_q) + SUM_W'(m_cy_q) + (SUM_W'(oy_m_q) <<< FRAC_W) + ROUND_HALF;
    end
  end

  assign sat_x = frt_sat(sx_q);
  assign sat_y = frt_sat(sy_q);

  always_comb begin
    res_d.overflow = sat_x[COORD_W] | sat_y[COORD_W];
    res_d.out_x    = sat_x[COORD_W-1:0];
    res_d.out_y    = sat_y[COORD_W-1:0];
  end

  // ---------------- output register and skid ----------------
  logic out_fire, take;

  assign out_fire = out_v_q && !out_stall_i;
  assign take     = en && post_v_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_fire) begin
        skid_v_q <= 1'b0;
      end
    end else if (take) begin
      if (out_v_q && !out_fire) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_fire) begin
        out_res_q <= skid_res_q;
      end
    end else if (take) begin
      if (out_v_q && !out_fire) begin
        skid_res_q <= res_d;
      end else begin
        out_res_q <= res_d;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_x_o     = out_res_q.out_x;
  assign out_y_o     = out_res_q.out_y;
  assign overflow_o  = out_res_q.overflow;

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a result while output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && out_stall_i))
    else $error("skid filled without a stalled output");

  a_frozen_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |=> ($stable(pre_v_q) && $stable(post_v_q)))
    else $error("pipeline moved while skid was full");

endmodule

`default_nettype wire

/* src/frt_cordic.sv */
// pipelined cordic rotation: cosine and sine of a folded binary angle
`default_nettype none

module frt_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [frt_pkg::ZR_W-1:0]   z_i,
  input  frt_pkg::frt_side_t                side_i,
  output logic                              valid_o,
  output logic signed [frt_pkg::TRIG_W-1:0] cos_o,
  output logic signed [frt_pkg::TRIG_W-1:0] sin_o,
  output frt_pkg::frt_side_t                side_o
);
  import frt_pkg::*;

  localparam int N = CORDIC_STAGES;

  logic [N:0]             v_q;
  logic signed [CS_W-1:0] x_q  [N+1];
  logic signed [CS_W-1:0] y_q  [N+1];
  logic signed [ZR_W-1:0] z_q  [N+1];
  frt_side_t              sd_q [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= CORDIC_GAIN;
      y_q[0]  <= '0;
      z_q[0]  <= z_i;
      sd_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [CS_W-1:0] xs, ys, x_d, y_d;
    logic signed [ZR_W-1:0] at, z_d;

    assign at = $signed({1'b0, ATAN_TURN32[i]});
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_comb begin
      if (!z_q[i][ZR_W-1]) begin
        x_d = x_q[i] - ys;
        y_d = y_q[i] + xs;
        z_d = z_q[i] - at;
      end else begin
        x_d = x_q[i] + ys;
        y_d = y_q[i] - xs;
        z_d = z_q[i] + at;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]  <= x_d;
        y_q[i+1]  <= y_d;
        z_q[i+1]  <= z_d;
        sd_q[i+1] <= sd_q[i];
      end
    end
  end

  assign valid_o = v_q[N];
  assign cos_o   = x_q[N][TRIG_W-1:0];
  assign sin_o   = y_q[N][TRIG_W-1:0];
  assign side_o  = sd_q[N];

endmodule

`default_nettype wire

/* dv/tb_frame_rotate_translate.sv */
// self-checking testbench for the frame rotate/translate pipeline
`default_nettype none

module tb_frame_rotate_translate;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = frt_pkg::ROTATION_STAGES + 10;
  localparam int TRIG_STAGES = (frt_pkg::ROTATION_STAGES < 24) ? frt_pkg::ROTATION_STAGES : 24;
  localparam int CLIP_MAX    = 8388607;
  localparam int CLIP_MIN    = -8388608;
  localparam longint UNIT_GAIN = 64'sd652032874;
  localparam longint HALF_LSB  = 64'sd536870912;
  localparam longint QUARTER   = 64'sd1073741824;
  localparam longint HALF_TURN = 64'sd2147483648;
  localparam longint FULL_TURN = 64'sd4294967296;

  // arctangent of 2^-i, full turn = 2^32
  localparam longint ATAN_STEP [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic {
    TO_WORLD = 1'b0,
    TO_ROBOT = 1'b1
  } xform_dir_e;

  typedef struct packed {
    xform_dir_e         dir;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] pose_x;
    logic signed [23:0] pose_y;
    logic signed [16:0] heading;
  } xform_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic req_type_i = 1'b0;
  logic signed [23:0] point_x_i = '0;
  logic signed [23:0] point_y_i = '0;
  logic signed [23:0] pose_x_i = '0;
  logic signed [23:0] pose_y_i = '0;
  logic signed [16:0] pose_heading_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [23:0] out_x_o;
  logic signed [23:0] out_y_o;
  logic overflow_o;

  frt_pkg::frt_res_t pending_results[$];
  frt_pkg::frt_res_t head_result;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int mismatches = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int overflow_seen = 0;
  int input_stall_cycles = 0;

  frame_rotate_translate dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .pose_x_i      (pose_x_i),
    .pose_y_i      (pose_y_i),
    .pose_heading_i(pose_heading_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .overflow_o    (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  // cosine and sine in q30 from a heading in hundredths of a degree
  function automatic void heading_trig(input logic signed [16:0] heading,
                                       output longint cos_q30, output longint sin_q30);
    longint h, z, x, y, xs, ys;
    bit flip;
    h = longint'(heading);
    h = h % 36000;
    if (h < 0) h += 36000;
    z = ((h <<< 32) + 18000) / 36000;
    if (z >= HALF_TURN) z -= FULL_TURN;
    flip = 1'b0;
    // fold the back half-plane into +-90 degrees, negate at the end
    if (z > QUARTER) begin
      z -= HALF_TURN;
      flip = 1'b1;
    end else if (z < -QUARTER) begin
      z += HALF_TURN;
      flip = 1'b1;
    end
    x = UNIT_GAIN;
    y = 0;
    for (int i = 0; i < TRIG_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= ATAN_STEP[i];
      end else begin
        x += ys;
        y -= xs;
        z += ATAN_STEP[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cos_q30 = x;
    sin_q30 = y;
  endfunction

  function automatic logic signed [23:0] clip_coord(input longint v, inout logic ovf);
    if (v > CLIP_MAX) begin
      ovf = 1'b1;
      return 24'(CLIP_MAX);
    end
    if (v < CLIP_MIN) begin
      ovf = 1'b1;
      return 24'(CLIP_MIN);
    end
    return v[23:0];
  endfunction

  function automatic frt_pkg::frt_res_t predict_transform(input xform_req_t req);
    longint c, s, px, py, rx, ry, dx, dy, sum_x, sum_y;
    frt_pkg::frt_res_t res;
    logic ovf;
    heading_trig(req.heading, c, s);
    px = longint'(req.point_x);
    py = longint'(req.point_y);
    rx = longint'(req.pose_x);
    ry = longint'(req.pose_y);
    if (req.dir == TO_WORLD) begin
      sum_x = c * px - s * py + (rx <<< 30);
      sum_y = s * px + c * py + (ry <<< 30);
    end else begin
      dx = px - rx;
      dy = py - ry;
      sum_x = c * dx + s * dy;
      sum_y = c * dy - s * dx;
    end
    ovf = 1'b0;
    res.out_x = clip_coord((sum_x + HALF_LSB) >>> 30, ovf);
    res.out_y = clip_coord((sum_y + HALF_LSB) >>> 30, ovf);
    res.overflow = ovf;
    return res;
  endfunction

  function automatic xform_req_t make_request(input xform_dir_e dir,
                                              input int px, input int py,
                                              input int rx, input int ry, input int hdg);
    xform_req_t req;
    req.dir = dir;
    req.point_x = 24'(px);
    req.point_y = 24'(py);
    req.pose_x = 24'(rx);
    req.pose_y = 24'(ry);
    req.heading = 17'(hdg);
    return req;
  endfunction

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'(int'($urandom_range(8191)) - 4096);
      2: return $urandom_range(1) ? 24'(CLIP_MAX - int'($urandom_range(255)))
                                  : 24'(CLIP_MIN + int'($urandom_range(255)));
      default: return 24'(int'($urandom_range(2097151)) - 1048576);
    endcase
  endfunction

  function automatic logic signed [16:0] rand_heading();
    case ($urandom_range(2))
      0: return 17'(int'($urandom_range(72000)) - 36000);
      1: return 17'($urandom);
      // near multiples of 45 degrees, including the quadrant edges where the fold kicks in
      default: return 17'(4500 * int'($urandom_range(16)) - 36000
                          + int'($urandom_range(2)) - 1);
    endcase
  endfunction

  function automatic xform_req_t random_request();
    return make_request(xform_dir_e'($urandom_range(1)), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_heading());
  endfunction

  // one request through the handshake; expectation is queued at acceptance
  task automatic send_request(input xform_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= req.dir;
    point_x_i      <= req.point_x;
    point_y_i      <= req.point_y;
    pose_x_i       <= req.pose_x;
    pose_y_i       <= req.pose_y;
    pose_heading_i <= req.heading;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) begin
      input_stall_cycles++;
      @(posedge clk_i);
    end
    pending_results.push_back(predict_transform(req));
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result x=%0d y=%0d ovf=%0b",
                   $realtime, out_x_o, out_y_o, overflow_o);
      end else begin
        head_result = pending_results.pop_front();
        results_checked++;
        if (overflow_o === 1'b1) overflow_seen++;
        if (out_x_o !== head_result.out_x || out_y_o !== head_result.out_y ||
            overflow_o !== head_result.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result %0d: expected x=%0d y=%0d ovf=%0b, got x=%0d y=%0d ovf=%0b",
                     $realtime, results_checked, head_result.out_x, head_result.out_y,
                     head_result.overflow, out_x_o, out_y_o, overflow_o);
        end
      end
    end
  end

  task automatic test_directed_cases();
    set_idling(0, 0);
    send_request(make_request(TO_WORLD, 0, 0, 0, 0, 0));
    send_request(make_request(TO_WORLD, CLIP_MAX, CLIP_MAX, CLIP_MAX, CLIP_MAX, 0));
    send_request(make_request(TO_WORLD, CLIP_MIN, CLIP_MIN, CLIP_MIN, CLIP_MIN, 0));
    send_request(make_request(TO_ROBOT, CLIP_MAX, CLIP_MIN, CLIP_MIN, CLIP_MAX, 0));
    send_request(make_request(TO_ROBOT, CLIP_MIN, CLIP_MAX, CLIP_MAX, CLIP_MIN, 18000));
    send_request(make_request(TO_WORLD, 25600, 0, 0, 0, 9000));
    send_request(make_request(TO_WORLD, 25600, -12800, 512, -512, 18000));
    send_request(make_request(TO_WORLD, 25600, 12800, 0, 0, 27000));
    // headings outside one turn wrap around
    send_request(make_request(TO_WORLD, 25600, 12800, 100, 200, 36000));
    send_request(make_request(TO_WORLD, 25600, 12800, 100, 200, -36000));
    send_request(make_request(TO_ROBOT, 25600, 12800, 100, 200, -65536));
    send_request(make_request(TO_ROBOT, 25600, 12800, 100, 200, 65535));
    send_request(make_request(TO_WORLD, 1000000, -1000000, 0, 0, -1));
    send_request(make_request(TO_WORLD, 1000000, -1000000, 0, 0, 1));
    send_request(make_request(TO_ROBOT, 1000000, -1000000, 5, 7, 35999));
    send_request(make_request(TO_ROBOT, 3000000, 3000000, -3000000, -3000000, 4500));
    send_request(make_request(TO_ROBOT, 3000000, -3000000, 0, 0, -9000));
    send_request(make_request(TO_WORLD, 7, -7, CLIP_MAX - 3, CLIP_MIN + 3, 13500));
    send_request(make_request(TO_WORLD, -1, -1, 0, 0, 3000));
    // just either side of the quadrant fold
    send_request(make_request(TO_ROBOT, 400000, 300000, 1000, 2000, 9001));
    send_request(make_request(TO_ROBOT, 400000, 300000, 1000, 2000, 8999));
    send_request(make_request(TO_WORLD, -400000, 300000, 1000, 2000, 27001));
    wait_drained();
  endtask

  task automatic test_streaming();
    set_idling(0, 0);
    repeat (130) send_request(random_request());
    wait_drained();
  endtask

  task automatic test_sparse_requests();
    set_idling(86, 0);
    repeat (110) send_request(random_request());
    wait_drained();
  endtask

  task automatic test_slow_drain();
    set_idling(0, 86);
    repeat (110) send_request(random_request());
    wait_drained();
  endtask

  task automatic test_both_idle();
    set_idling(27, 27);
    repeat (130) send_request(random_request());
    wait_drained();
  endtask

  // receiver holds off long enough for the pipe and skid stage to fill
  task automatic test_backpressure_fill();
    set_idling(0, 0);
    hold_request = 4 * LATENCY + 100;
    repeat (60) send_request(random_request());
    wait_drained();
  endtask

  task automatic test_pause_until_drained();
    set_idling(27, 27);
    repeat (4) begin
      repeat (20) send_request(random_request());
      wait_drained();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_streaming();
    test_sparse_requests();
    test_slow_drain();
    test_both_idle();
    test_backpressure_fill();
    test_pause_until_drained();
    set_idling(0, 0);
    repeat (LATENCY + 8) @(posedge clk_i);
    $display("covered %0d requests both ways, idle and stall mixes, long hold-off",
             requests_sent);
    $display("%0d results checked, %0d saturated, %0d cycles of input back-pressure",
             results_checked, overflow_seen, input_stall_cycles);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
